// ===== design/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants of the sha-1 engine
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam logic [31:0] SHA1_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_P1  = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_P2  = 32'hCA62C1D6;

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam logic [6:0] SCHED_SPAN  = 7'd16;
    localparam logic [6:0] PHASE1_END  = 7'd20;
    localparam logic [6:0] PHASE2_END  = 7'd40;
    localparam logic [6:0] PHASE3_END  = 7'd60;
    localparam logic [6:0] LAST_ROUND  = 7'd79;

    localparam logic [3:0] LEN_POS     = 4'd14;
    localparam logic [3:0] LAST_SLOT   = 4'd15;

    localparam logic [2:0] DIGEST_LAST_IDX = 3'd4;

    // one classified message beat
    typedef struct packed {
        logic [31:0] word;
        logic [5:0]  nbits;
        logic        last;
        logic        pad80;
    } sha1_item_t;

endpackage

// ===== design/sha1_msg_if.sv =====
// ----------------------------------------------------------------------------
// sha1_msg_if
// message word channel
// ----------------------------------------------------------------------------
interface sha1_msg_if;

    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        last_word;

    modport source (
        output valid,
        output msg_word,
        output valid_bytes,
        output last_word,
        input  ready
    );

    modport sink (
        input  valid,
        input  msg_word,
        input  valid_bytes,
        input  last_word,
        output ready
    );

endinterface

// ===== design/sha1_digest_if.sv =====
// ----------------------------------------------------------------------------
// sha1_digest_if
// digest word channel
// ----------------------------------------------------------------------------
interface sha1_digest_if;

    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    modport source (
        output valid,
        output digest_word,
        output digest_index,
        output digest_last,
        input  ready
    );

    modport sink (
        input  valid,
        input  digest_word,
        input  digest_index,
        input  digest_last,
        output ready
    );

endinterface

// ===== design/sha1_front.sv =====
// ----------------------------------------------------------------------------
// sha1_front
// accepts message beats, trims the final word and inserts the pad byte
// ----------------------------------------------------------------------------
module sha1_front
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sha1_msg_if.sink   msg,
    output logic       item_valid,
    input  logic       item_ready,
    output sha1_item_t item
);

    logic       valid_reg;
    sha1_item_t item_reg;
    sha1_item_t item_next;
    logic [2:0] nbytes;
    logic       accept;

    assign nbytes = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;

    always_comb
    begin
        item_next.last  = msg.last_word;
        item_next.pad80 = msg.last_word && (nbytes == 3'd4);
        item_next.nbits = msg.last_word ? {nbytes, 3'b000} : 6'd32;
        item_next.word  = msg.msg_word;
        if (msg.last_word)
        begin
            case (nbytes)
                3'd0:    item_next.word = PAD_WORD;
                3'd1:    item_next.word = {msg.msg_word[31:24], 8'h80, 16'h0000};
                3'd2:    item_next.word = {msg.msg_word[31:16], 8'h80, 8'h00};
                3'd3:    item_next.word = {msg.msg_word[31:8], 8'h80};
                default: item_next.word = msg.msg_word;
            endcase
        end
    end

    assign msg.ready  = !valid_reg || item_ready;
    assign accept     = msg.valid && msg.ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/sha1_fifo.sv =====
// ----------------------------------------------------------------------------
// sha1_fifo
// short queue of classified beats between front and back
// ----------------------------------------------------------------------------
module sha1_fifo
    import sha1_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_valid,
    output logic       wr_ready,
    input  sha1_item_t wr_item,
    output logic       rd_valid,
    input  logic       rd_ready,
    output sha1_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sha1_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (cnt_reg != CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== design/sha1_back.sv =====
// ----------------------------------------------------------------------------
// sha1_back
// block assembly, length padding, 80-round compression and digest output
// ----------------------------------------------------------------------------
module sha1_back
    import sha1_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  sha1_item_t    q_item,
    sha1_digest_if.source digest
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PAD   = 4'b0010,
        ST_ROUND = 4'b0100,
        ST_FOLD  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  wc_reg, wc_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [63:0] blen_reg, blen_next;
    logic        tail_reg, tail_next;
    logic        pad80_reg, pad80_next;
    logic        lenhi_reg, lenhi_next;
    logic        fin_reg, fin_next;
    logic        busy_reg, busy_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] work_reg [5];
    logic [31:0] work_next [5];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] dig_reg [5];
    logic [31:0] dig_next [5];
    logic        dig_load;

    logic        push_en;
    logic [31:0] push_data;
    logic [31:0] sched_x;
    logic [31:0] w_t;
    logic [31:0] f_t;
    logic [31:0] k_t;
    logic [31:0] a_rot;
    logic [31:0] tmp;

    // round datapath
    always_comb
    begin
        sched_x = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_t = (rnd_reg < SCHED_SPAN) ? win_reg[0] : {sched_x[30:0], sched_x[31]};
        if (rnd_reg < PHASE1_END)
        begin
            f_t = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_t = K_CH;
        end
        else if (rnd_reg < PHASE2_END)
        begin
            f_t = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_t = K_P1;
        end
        else if (rnd_reg < PHASE3_END)
        begin
            f_t = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                | (work_reg[2] & work_reg[3]);
            k_t = K_MAJ;
        end
        else
        begin
            f_t = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_t = K_P2;
        end
        a_rot = {work_reg[0][26:0], work_reg[0][31:27]};
        tmp   = a_rot + f_t + work_reg[4] + k_t + w_t;
    end

    assign q_ready = (state_reg == ST_LOAD);

    always_comb
    begin
        state_next = state_reg;
        wc_next    = wc_reg;
        rnd_next   = rnd_reg;
        blen_next  = blen_reg;
        tail_next  = tail_reg;
        pad80_next = pad80_reg;
        lenhi_next = lenhi_reg;
        fin_next   = fin_reg;
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        win_next   = win_reg;
        dig_next   = dig_reg;
        dig_load   = 1'b0;
        push_en    = 1'b0;
        push_data  = '0;

        // digest output
        if (busy_reg && digest.ready)
        begin
            idx_next = idx_reg + 3'd1;
            if (idx_reg == DIGEST_LAST_IDX)
            begin
                busy_next = 1'b0;
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    push_en   = 1'b1;
                    push_data = q_item.word;
                    blen_next = blen_reg + 64'(q_item.nbits);
                    if (q_item.last)
                    begin
                        tail_next  = 1'b1;
                        pad80_next = q_item.pad80;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (pad80_reg)
                begin
                    push_data  = PAD_WORD;
                    pad80_next = 1'b0;
                end
                else if (lenhi_reg)
                begin
                    push_data  = blen_reg[31:0];
                    lenhi_next = 1'b0;
                    fin_next   = 1'b1;
                end
                else if (wc_reg == LEN_POS)
                begin
                    push_data  = blen_reg[63:32];
                    lenhi_next = 1'b1;
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[15] = w_t;
                work_next[4] = work_reg[3];
                work_next[3] = work_reg[2];
                work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
                work_next[1] = work_reg[0];
                work_next[0] = tmp;
                rnd_next     = rnd_reg + 7'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (fin_reg)
                begin
                    if (!busy_reg)
                    begin
                        dig_load = 1'b1;
                        for (int i = 0; i < 5; i++)
                        begin
                            dig_next[i] = chain_reg[i] + work_reg[i];
                        end
                        chain_next = SHA1_INIT;
                        blen_next  = '0;
                        fin_next   = 1'b0;
                        tail_next  = 1'b0;
                        busy_next  = 1'b1;
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        chain_next[i] = chain_reg[i] + work_reg[i];
                    end
                    state_next = tail_reg ? ST_PAD : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // schedule window fill, a full block starts compression
        if (push_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[15] = push_data;
            wc_next      = wc_reg + 4'd1;
            if (wc_reg == LAST_SLOT)
            begin
                state_next = ST_ROUND;
                rnd_next   = '0;
                work_next  = chain_reg;
            end
        end
    end

    assign digest.valid        = busy_reg;
    assign digest.digest_word  = dig_reg[idx_reg];
    assign digest.digest_index = idx_reg;
    assign digest.digest_last  = (idx_reg == DIGEST_LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            wc_reg    <= '0;
            rnd_reg   <= '0;
            blen_reg  <= '0;
            tail_reg  <= 1'b0;
            pad80_reg <= 1'b0;
            lenhi_reg <= 1'b0;
            fin_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            chain_reg <= SHA1_INIT;
        end
        else
        begin
            state_reg <= state_next;
            wc_reg    <= wc_next;
            rnd_reg   <= rnd_next;
            blen_reg  <= blen_next;
            tail_reg  <= tail_next;
            pad80_reg <= pad80_next;
            lenhi_reg <= lenhi_next;
            fin_reg   <= fin_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        win_reg  <= win_next;
        if (dig_load)
        begin
            dig_reg <= dig_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_round_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && rnd_reg == LAST_ROUND) |=> state_reg == ST_FOLD)
        else $error("compression did not end after the last round");

    a_fold_block_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FOLD |-> wc_reg == 4'd0)
        else $error("fold with a partial block");

    a_len_lo_slot: assert property (@(posedge clk) disable iff (!rst_n)
        lenhi_reg |-> wc_reg == LAST_SLOT)
        else $error("length low word not at the last slot");

    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD && fin_reg && busy_reg) |=> (state_reg == ST_FOLD && fin_reg))
        else $error("digest overwritten while still being sent");
`endif

endmodule

// ===== design/sha1_hash_engine.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine
// streaming sha-1 digest with built-in message padding
// ----------------------------------------------------------------------------
// msg carries one beat per message word: up to four bytes, first byte in
// bits 31..24, a byte count and a last-word mark. digest returns five beats,
// h0 first, the fifth marked last.
// a beat passes a registered front stage and a short queue to the back end.
// the back end takes one word per cycle into the schedule window while it
// is loading; it takes no words while a full block runs through the rounds
// (one round per cycle) and the fold, so sustained input is set by the
// single round unit. after the last word the back end adds padding and the
// length one word at a time, completing the current block and at most one
// extra block.
// reset loads the initial chaining values, empties the queue and idles the
// digest channel. a digest waits in its own buffer while the receiver stalls;
// words of the next message keep flowing until its own digest is due.
// ----------------------------------------------------------------------------
module sha1_hash_engine
    import sha1_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    sha1_msg_if.sink      msg,
    sha1_digest_if.source digest
);

    logic       f_valid;
    logic       f_ready;
    sha1_item_t f_item;
    logic       q_valid;
    logic       q_ready;
    sha1_item_t q_item;

    sha1_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    sha1_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    sha1_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .digest  (digest)
    );

endmodule
